FILE: hw/rtl/voxst_pkg.sv
package voxst_pkg;

  typedef enum logic [1:0] {
    REQ_READ      = 2'd0,
    REQ_WRITE     = 2'd1,
    REQ_CLR_DIRTY = 2'd2,
    REQ_SET_DIRTY = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic clr;
    logic latch;
    logic eval;
    logic scan_rd;
    logic scan_chk;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic need_scan;
    logic scan_hit;
    logic scan_last;
  } dp_stat_t;

endpackage

FILE: hw/rtl/voxel_store_with_heightmap.sv
// Voxel block store with a per-column height map.
// Input channel (in_valid_i/in_ready_o) carries one request: read, write,
// clear dirty or set dirty, at signed coordinates x_i, y_i, z_i.
// Output channel (out_valid_o/out_ready_i) returns one result per request:
// block code, column height (-1 for an empty or out-of-range column),
// dirty flag, in-bounds flag and changed flag.
// Reset: the block sweeps both memories, one entry a cycle, through all
// SIZE_X*SIZE_Y*SIZE_Z block entries (65536 by default) with in_ready_o low;
// the dirty flag comes up set.
// The result passes through the registered block memory read, the evaluate
// and write state and the output load; a new request is taken only after the
// previous result has been loaded into the output register.
// Clearing the top block of a column adds a downward rescan, one read state
// and one check state per level, through the same memory read port.
// A stalled result stays in the output register; one further request is
// taken meanwhile and its result waits until the register frees.
module voxel_store_with_heightmap #(
  parameter int SIZE_X     = 16,
  parameter int SIZE_Y     = 256,
  parameter int SIZE_Z     = 16,
  parameter int BLOCK_BITS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        req_type_i,
  input  logic signed [5:0] x_i,
  input  logic signed [9:0] y_i,
  input  logic signed [5:0] z_i,
  input  logic [7:0]        block_value_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        block_out_o,
  output logic signed [8:0] column_height_o,
  output logic              dirty_o,
  output logic              in_bounds_o,
  output logic              changed_o
);

  import voxst_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  voxst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  voxst_dp #(
    .SIZE_X     (SIZE_X),
    .SIZE_Y     (SIZE_Y),
    .SIZE_Z     (SIZE_Z),
    .BLOCK_BITS (BLOCK_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .req_type_i      (req_type_i),
    .x_i             (x_i),
    .y_i             (y_i),
    .z_i             (z_i),
    .block_value_i   (block_value_i),
    .block_out_o     (block_out_o),
    .column_height_o (column_height_o),
    .dirty_o         (dirty_o),
    .in_bounds_o     (in_bounds_o),
    .changed_o       (changed_o)
  );

endmodule

FILE: hw/rtl/voxst_ram.sv
module voxst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: hw/rtl/voxst_dp.sv
module voxst_dp #(
  parameter int SIZE_X     = 16,
  parameter int SIZE_Y     = 256,
  parameter int SIZE_Z     = 16,
  parameter int BLOCK_BITS = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  voxst_pkg::ctrl_cmd_t   cmd_i,
  output voxst_pkg::dp_stat_t    stat_o,
  input  logic [1:0]             req_type_i,
  input  logic signed [5:0]      x_i,
  input  logic signed [9:0]      y_i,
  input  logic signed [5:0]      z_i,
  input  logic [7:0]             block_value_i,
  output logic [7:0]             block_out_o,
  output logic signed [8:0]      column_height_o,
  output logic                   dirty_o,
  output logic                   in_bounds_o,
  output logic                   changed_o
);

  import voxst_pkg::*;

  localparam int COLS  = SIZE_X * SIZE_Z;
  localparam int CELLS = COLS * SIZE_Y;
  localparam int CW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int COLW  = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int XW    = (SIZE_X > 1) ? $clog2(SIZE_X) : 1;
  localparam int ZW    = (SIZE_Z > 1) ? $clog2(SIZE_Z) : 1;
  localparam int YW    = (SIZE_Y > 1) ? $clog2(SIZE_Y) : 1;
  localparam int HW    = $clog2(SIZE_Y) + 1;

  function automatic logic [COLW-1:0] col_addr(input logic [5:0] xv, input logic [5:0] zv);
    logic [31:0] a;
    a = 32'(zv[ZW-1:0]) * 32'(SIZE_X) + 32'(xv[XW-1:0]);
    return a[COLW-1:0];
  endfunction

  function automatic logic [CW-1:0] cell_addr(input logic [YW-1:0] lv,
                                               input logic [COLW-1:0] col);
    logic [31:0] a;
    a = 32'(lv) * 32'(COLS) + 32'(col);
    return a[CW-1:0];
  endfunction

  req_e                   req_q;
  logic [5:0]             x_q, z_q;
  logic [9:0]             y_q;
  logic [BLOCK_BITS-1:0]  val_q;
  logic [BLOCK_BITS-1:0]  blk_q;
  logic signed [HW-1:0]   ht_q;
  logic                   chg_q;
  logic                   dirty_q;
  logic [YW-1:0]          lvl_q;
  logic [CW-1:0]          clr_cnt_q;

  logic                   x_ok, y_ok, z_ok, col_ok, ok;
  logic [COLW-1:0]        col;
  logic [CW-1:0]          cell_idx;
  logic [BLOCK_BITS-1:0]  blk_rd;
  logic signed [HW-1:0]   ht_rd;
  logic                   wr_chg, raise;
  logic                   blk_we, ht_we;
  logic [CW-1:0]          blk_waddr, blk_raddr;
  logic [BLOCK_BITS-1:0]  blk_wdata;
  logic [COLW-1:0]        ht_waddr, ht_raddr;
  logic signed [HW-1:0]   ht_wdata;
  logic signed [HW-1:0]   lvl_ht;
  logic signed [9:0]      ht_ext;

  assign x_ok     = !x_q[5] && (32'(x_q[4:0]) < SIZE_X);
  assign z_ok     = !z_q[5] && (32'(z_q[4:0]) < SIZE_Z);
  assign y_ok     = !y_q[9] && (32'(y_q[8:0]) < SIZE_Y);
  assign col_ok   = x_ok && z_ok;
  assign ok       = col_ok && y_ok;
  assign col      = col_addr(x_q, z_q);
  assign cell_idx = cell_addr(y_q[YW-1:0], col);
  assign lvl_ht   = HW'(lvl_q);

  assign wr_chg = (req_q == REQ_WRITE) && ok && (blk_rd != val_q);
  assign raise  = wr_chg && (val_q != '0) && ($signed(y_q) > ht_rd);

  assign stat_o.clr_done  = (clr_cnt_q == CW'(CELLS - 1));
  assign stat_o.need_scan = wr_chg && (val_q == '0) && ($signed(y_q) == ht_rd);
  assign stat_o.scan_hit  = (blk_rd != '0);
  assign stat_o.scan_last = (lvl_q == '0);

  always_comb begin
    blk_we    = 1'b0;
    blk_waddr = cell_idx;
    blk_wdata = val_q;
    if (cmd_i.clr) begin
      blk_we    = 1'b1;
      blk_waddr = clr_cnt_q;
      blk_wdata = '0;
    end else if (cmd_i.eval) begin
      blk_we    = wr_chg;
    end
  end

  always_comb begin
    if (cmd_i.latch) begin
      blk_raddr = cell_addr(y_i[YW-1:0], col_addr(x_i, z_i));
    end else begin
      blk_raddr = cell_addr(lvl_q, col);
    end
  end

  assign ht_raddr = col_addr(x_i, z_i);

  always_comb begin
    ht_we    = 1'b0;
    ht_waddr = col;
    ht_wdata = HW'($signed(y_q));
    if (cmd_i.clr) begin
      ht_we    = (32'(clr_cnt_q) < COLS);
      ht_waddr = clr_cnt_q[COLW-1:0];
      ht_wdata = '1;
    end else if (cmd_i.eval) begin
      ht_we    = raise;
    end else if (cmd_i.scan_chk) begin
      ht_we    = stat_o.scan_hit || stat_o.scan_last;
      ht_wdata = stat_o.scan_hit ? lvl_ht : '1;
    end
  end

  voxst_ram #(
    .WIDTH (BLOCK_BITS),
    .DEPTH (CELLS)
  ) u_blk_ram (
    .clk_i   (clk_i),
    .we_i    (blk_we),
    .waddr_i (blk_waddr),
    .wdata_i (blk_wdata),
    .raddr_i (blk_raddr),
    .rdata_o (blk_rd)
  );

  voxst_ram #(
    .WIDTH (HW),
    .DEPTH (COLS)
  ) u_ht_ram (
    .clk_i   (clk_i),
    .we_i    (ht_we),
    .waddr_i (ht_waddr),
    .wdata_i (ht_wdata),
    .raddr_i (ht_raddr),
    .rdata_o (ht_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
      dirty_q   <= 1'b1;
    end else begin
      if (cmd_i.clr && !stat_o.clr_done) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (cmd_i.eval) begin
        if (wr_chg || req_q == REQ_SET_DIRTY) begin
          dirty_q <= 1'b1;
        end else if (req_q == REQ_CLR_DIRTY) begin
          dirty_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_q <= req_e'(req_type_i);
      x_q   <= x_i;
      y_q   <= y_i;
      z_q   <= z_i;
      val_q <= BLOCK_BITS'(block_value_i);
    end
    if (cmd_i.eval) begin
      blk_q <= ok ? (wr_chg ? val_q : blk_rd) : '0;
      ht_q  <= col_ok ? (raise ? HW'($signed(y_q)) : ht_rd) : '1;
      chg_q <= wr_chg;
      lvl_q <= YW'(SIZE_Y - 1);
    end
    if (cmd_i.scan_chk) begin
      if (stat_o.scan_hit) begin
        ht_q <= lvl_ht;
      end else if (stat_o.scan_last) begin
        ht_q <= '1;
      end else begin
        lvl_q <= lvl_q - 1'b1;
      end
    end
  end

  assign ht_ext = 10'(ht_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      block_out_o     <= 8'(blk_q);
      column_height_o <= ht_ext[8:0];
      dirty_o         <= dirty_q;
      in_bounds_o     <= ok;
      changed_o       <= chg_q;
    end
  end

endmodule

FILE: hw/rtl/voxst_ctrl.sv
module voxst_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output voxst_pkg::ctrl_cmd_t cmd_o,
  input  voxst_pkg::dp_stat_t  stat_i
);

  import voxst_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (stat_i.clr_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EVAL;
      end
      ST_EVAL: begin
        state_d = stat_i.need_scan ? ST_SCAN_RD : ST_FIN;
      end
      ST_SCAN_RD: begin
        state_d = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        if (stat_i.scan_hit || stat_i.scan_last) begin
          state_d = ST_FIN;
        end else begin
          state_d = ST_SCAN_RD;
        end
      end
      ST_FIN: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr = 1'b1;
      end
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.latch = in_valid_i;
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
      end
      ST_SCAN_RD: begin
        cmd_o.scan_rd = 1'b1;
      end
      ST_SCAN_CHK: begin
        cmd_o.scan_chk = 1'b1;
      end
      ST_FIN: begin
        cmd_o.load_out = out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.load_out) out_valid_d = 1'b1;
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: hw/rtl/voxst_chk.sv
module voxst_chk (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic [1:0]        req_type_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [7:0]        block_out_o,
  input logic signed [8:0] column_height_o,
  input logic              dirty_o,
  input logic              in_bounds_o,
  input logic              changed_o
);

  import voxst_pkg::*;

  logic [1:0] req_fifo_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] pend_q;
  logic       in_xfer, out_xfer;
  logic [1:0] head_req;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_o && out_ready_i;
  assign head_req = req_fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      pend_q   <= '0;
    end else begin
      if (in_xfer) wr_ptr_q <= !wr_ptr_q;
      if (out_xfer) rd_ptr_q <= !rd_ptr_q;
      pend_q <= pend_q + {1'b0, in_xfer} - {1'b0, out_xfer};
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) req_fifo_q[wr_ptr_q] <= req_type_i;
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(block_out_o)
      && $stable(column_height_o) && $stable(dirty_o) && $stable(changed_o))
    else $error("result changed while stalled");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 2'd0 && pend_q != 2'd3)
    else $error("result without a pending request");

  a_oob_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !in_bounds_o |-> block_out_o == 8'd0 && !changed_o)
    else $error("out-of-range result reports a block or a change");

  a_dirty_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer |-> (head_req != REQ_CLR_DIRTY || !dirty_o)
      && (head_req != REQ_SET_DIRTY || dirty_o) && (!changed_o || dirty_o))
    else $error("dirty flag disagrees with the request");

  a_chg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && changed_o |-> head_req == REQ_WRITE)
    else $error("change reported for a non-write request");

endmodule

bind voxel_store_with_heightmap voxst_chk u_chk (.*);
